/* hw/rtl/lcg_pkg.sv */
// Shared constants and types for the 64-bit LCG with skip-ahead.
package lcg_pkg;

    // Step constants of the affine map x' = A*x + C mod 2^64
    localparam logic [63:0] LCG_A = 64'd6364136223846793005;
    localparam logic [63:0] LCG_C = 64'd1;

    // Command codes
    localparam logic CMD_NEXT = 1'b0;
    localparam logic CMD_SEED = 1'b1;

    // Request to the shared multiply-add unit: p = a*b + c mod 2^64
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
    } t_mul_req;

    // Response from the shared multiply-add unit
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] p;
    } t_mul_rsp;

endpackage

/* hw/rtl/lcg_mul.sv */
// Iterative 64-bit multiply-add (low half) on one 32x32 multiplier.
module lcg_mul
    import lcg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;
    logic [63:0] r_prod;
    logic [1:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_prod;
    logic [63:0] w_addend;

    // Select the partial product for this pass: lo*lo, lo*hi, hi*lo
    always_comb begin
        case (r_cnt)
            2'd0: begin
                w_ma = r_a[31:0];
                w_mb = r_b[31:0];
            end
            2'd1: begin
                w_ma = r_a[31:0];
                w_mb = r_b[63:32];
            end
            2'd2: begin
                w_ma = r_a[63:32];
                w_mb = r_b[31:0];
            end
            default: begin
                w_ma = 32'd0;
                w_mb = 32'd0;
            end
        endcase
    end

    // Full 64-bit product of the two unsigned 32-bit halves
    assign w_prod = {32'd0, w_ma} * {32'd0, w_mb};

    // The first product adds whole; cross terms only reach the upper half
    assign w_addend = (r_cnt == 2'd1) ? r_prod : {r_prod[31:0], 32'd0};

    // Latch operands, then one partial product and one accumulate per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_acc <= i_req.c;
        end else if (r_busy) begin
            r_prod <= w_prod;
            if (r_cnt != 2'd0) begin
                r_acc <= r_acc + w_addend;
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;

    // Done pulses only at the end of a busy pass
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |-> $past(r_busy) && !r_busy)
        else $error("multiply done without a pass");

    // Checks the length of a multiply pass from the rise of busy
    a_pass_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> ##4 !r_busy)
        else $error("multiply pass length wrong");

    // Done is a single-cycle pulse
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |=> !o_rsp.done)
        else $error("multiply done held");

endmodule

/* hw/rtl/lcg64_with_skip_ahead_unit.sv */
// Top level: 64-bit LCG (A = 6364136223846793005, C = 1) with seed by skip-ahead.
// Every multiply runs on one shared multiply-add unit that forms each 64-bit
// product from three 32x32 partial products on one multiplier. A next word
// takes one multiply-add. A seed word walks skip_count from the lowest bit up
// to its highest set bit: each set bit costs three multiply-adds plus a check
// and each clear bit two multiply-adds plus a check. The input is stalled
// while a word is in work; a finished word waits in the output register, so
// the next word is taken meanwhile.
module lcg64_with_skip_ahead_unit
    import lcg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [63:0] i_skip_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_value
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_NEXT     = 3'd1;
    localparam logic [2:0] S_CHECK    = 3'd2;
    localparam logic [2:0] S_SEED_ACC = 3'd3;
    localparam logic [2:0] S_SEED_ADD = 3'd4;
    localparam logic [2:0] S_SEED_MUL = 3'd5;
    localparam logic [2:0] S_OUT      = 3'd6;

    logic [2:0]  r_fsm;
    logic [2:0]  n_fsm;
    logic [63:0] r_gen;
    logic [63:0] n_gen;
    logic [63:0] r_mul;
    logic [63:0] n_mul;
    logic [63:0] r_add;
    logic [63:0] n_add;
    logic [63:0] r_acc;
    logic [63:0] n_acc;
    logic [63:0] r_rest;
    logic [63:0] n_rest;
    logic        r_out_valid;
    logic [63:0] r_out_value;

    logic        w_in_acc;
    logic        w_out_free;
    t_mul_req    w_req;
    t_mul_rsp    w_rsp;

    assign o_stall    = (r_fsm != S_IDLE);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    lcg_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    // Sequence the seed walk and the single step over the shared unit
    always_comb begin
        n_fsm       = r_fsm;
        n_gen       = r_gen;
        n_mul       = r_mul;
        n_add       = r_add;
        n_acc       = r_acc;
        n_rest      = r_rest;
        w_req.start = 1'b0;
        w_req.a     = r_mul;
        w_req.b     = r_acc;
        w_req.c     = r_add;
        case (r_fsm)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_command == CMD_SEED) begin
                        n_mul  = LCG_A;
                        n_add  = LCG_C;
                        n_acc  = 64'd1;
                        n_rest = i_skip_count;
                        n_fsm  = S_CHECK;
                    end else begin
                        w_req.start = 1'b1;
                        w_req.a     = LCG_A;
                        w_req.b     = r_gen;
                        w_req.c     = LCG_C;
                        n_fsm       = S_NEXT;
                    end
                end
            end
            S_NEXT: begin
                if (w_rsp.done) begin
                    n_gen = w_rsp.p;
                    n_fsm = S_OUT;
                end
            end
            S_CHECK: begin
                if (r_rest == 64'd0) begin
                    n_gen = r_acc;
                    n_fsm = S_OUT;
                end else if (r_rest[0]) begin
                    w_req.start = 1'b1;
                    n_fsm       = S_SEED_ACC;
                end else begin
                    w_req.start = 1'b1;
                    w_req.a     = r_add;
                    w_req.b     = r_mul + 64'd1;
                    w_req.c     = 64'd0;
                    n_fsm       = S_SEED_ADD;
                end
            end
            S_SEED_ACC: begin
                if (w_rsp.done) begin
                    n_acc       = w_rsp.p;
                    w_req.start = 1'b1;
                    w_req.a     = r_add;
                    w_req.b     = r_mul + 64'd1;
                    w_req.c     = 64'd0;
                    n_fsm       = S_SEED_ADD;
                end
            end
            S_SEED_ADD: begin
                if (w_rsp.done) begin
                    n_add       = w_rsp.p;
                    w_req.start = 1'b1;
                    w_req.a     = r_mul;
                    w_req.b     = r_mul;
                    w_req.c     = 64'd0;
                    n_fsm       = S_SEED_MUL;
                end
            end
            S_SEED_MUL: begin
                if (w_rsp.done) begin
                    n_mul  = w_rsp.p;
                    n_rest = {1'b0, r_rest[63:1]};
                    n_fsm  = S_CHECK;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_fsm = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    // Hold control state and generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= S_IDLE;
            r_gen <= 64'd0;
        end else begin
            r_fsm <= n_fsm;
            r_gen <= n_gen;
        end
    end

    // Advance the seed working registers
    always_ff @(posedge i_clk) begin
        r_mul  <= n_mul;
        r_add  <= n_add;
        r_acc  <= n_acc;
        r_rest <= n_rest;
    end

    // Load the output word when the register is free, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_fsm == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fsm == S_OUT && w_out_free) begin
            r_out_value <= r_gen;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;

    // An accepted word always leaves the idle state
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_fsm != S_IDLE)
        else $error("accepted word not taken into work");

    // No new multiply is issued while one is in flight
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_rsp.busy)
        else $error("multiply started while busy");

    // Products arrive only in a state that waits for one
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_fsm == S_NEXT || r_fsm == S_SEED_ACC
                        || r_fsm == S_SEED_ADD || r_fsm == S_SEED_MUL))
        else $error("multiply result in unexpected state");

    // A seed walk ends exactly when no set bits remain
    a_seed_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_CHECK && r_rest == 64'd0) |=> r_fsm == S_OUT && r_gen == $past(r_acc))
        else $error("seed walk ended wrongly");

endmodule
